>>> rtl/lzv_pkg.sv
`default_nettype none

package lzv_pkg;

   // Input beat: value to encode, or one byte of a stream to decode.
   typedef struct packed {
      logic [31:0] in_value;
      logic [7:0]  in_byte;
      logic        signed_mode;
   } req_type;

   // Result beat: one encoded byte, or one decoded value.
   typedef struct packed {
      logic [7:0]  out_byte;
      logic [31:0] out_value;
      logic        last;
   } rsp_type;

   // Work handed from the front end to the back end.
   typedef struct packed {
      logic        is_decode;
      logic [31:0] value;
   } job_type;

   localparam logic [7:0] ContBit   = 8'h80;
   localparam int unsigned GroupBits = 7;
   localparam int unsigned MaxGroups = 5;
   localparam int unsigned GroupW    = 3;

   // Queue depths, powers of two so the pointers wrap on their own.
   localparam int unsigned JobDepth = 2;
   localparam int unsigned JobPtrW  = $clog2(JobDepth);
   localparam int unsigned JobCntW  = $clog2(JobDepth + 1);
   localparam int unsigned OutDepth = 2;
   localparam int unsigned OutPtrW  = $clog2(OutDepth);
   localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

   function automatic logic [31:0] zz_map(input logic [31:0] v);
      return {v[30:0], 1'b0} ^ {32{v[31]}};
   endfunction

   function automatic logic [31:0] zz_unmap(input logic [31:0] z);
      return {1'b0, z[31:1]} ^ {32{z[0]}};
   endfunction

endpackage

`default_nettype wire

>>> rtl/lzv_front.sv
`default_nettype none

module lzv_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_we,
   input  wire               csr_wdata,
   input  wire               push,
   input  lzv_pkg::req_type  req_data,
   output logic              full,
   input  wire               jobq_full,
   output logic              job_push,
   output lzv_pkg::job_type  job_data
);

   logic                        mode_ff, mode_in;
   logic [31:0]                 acc_ff, acc_in;
   logic [lzv_pkg::GroupW-1:0]  group_ff, group_in;

   logic                        accept;
   logic [lzv_pkg::GroupW-1:0]  gi;
   logic [6:0]                  payload;
   logic [31:0]                 part;
   logic [31:0]                 merged;
   logic                        dec_end;

   assign full   = jobq_full;
   assign accept = push & ~jobq_full;

   // Out-of-range group counts are treated as the fifth byte.
   assign gi = (group_ff > lzv_pkg::GroupW'(lzv_pkg::MaxGroups - 1)) ?
               lzv_pkg::GroupW'(lzv_pkg::MaxGroups - 1) : group_ff;
   assign payload = req_data.in_byte[6:0];

   always_comb begin
      case (gi)
         3'd0:    part = {25'b0, payload};
         3'd1:    part = {18'b0, payload, 7'b0};
         3'd2:    part = {11'b0, payload, 14'b0};
         3'd3:    part = {4'b0, payload, 21'b0};
         default: part = {payload[3:0], 28'b0};
      endcase
   end

   assign merged  = acc_ff | part;
   assign dec_end = ((req_data.in_byte & lzv_pkg::ContBit) == 8'h00) ||
                    (gi == lzv_pkg::GroupW'(lzv_pkg::MaxGroups - 1));

   always_comb begin
      job_push           = accept & (~mode_ff | dec_end);
      job_data.is_decode = mode_ff;
      if (mode_ff) begin
         job_data.value = req_data.signed_mode ? lzv_pkg::zz_unmap(merged) : merged;
      end else begin
         job_data.value = req_data.signed_mode ? lzv_pkg::zz_map(req_data.in_value)
                                               : req_data.in_value;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      group_in = group_ff;
      if (csr_we) begin
         mode_in  = csr_wdata;
         acc_in   = '0;
         group_in = '0;
      end else if (accept && mode_ff) begin
         if (dec_end) begin
            acc_in   = '0;
            group_in = '0;
         end else begin
            acc_in   = merged;
            group_in = gi + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         acc_ff   <= '0;
         group_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         group_ff <= group_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lzv_jobq.sv
`default_nettype none

module lzv_jobq (
   input  wire               clock,
   input  wire               reset,
   input  wire               wr_en,
   input  lzv_pkg::job_type  wr_data,
   output logic              q_full,
   input  wire               rd_en,
   output logic              q_valid,
   output lzv_pkg::job_type  rd_data
);

   lzv_pkg::job_type               mem_ff [lzv_pkg::JobDepth];
   logic [lzv_pkg::JobPtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lzv_pkg::JobPtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lzv_pkg::JobCntW-1:0]    count_ff, count_in;
   logic                           do_wr, do_rd;

   assign q_full  = (count_ff == lzv_pkg::JobCntW'(lzv_pkg::JobDepth));
   assign q_valid = (count_ff != '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en & ~q_full;
   assign do_rd   = rd_en & q_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lzv_back.sv
`default_nettype none

module lzv_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               job_valid,
   input  lzv_pkg::job_type  job_data,
   output logic              job_pop,
   output logic              empty,
   input  wire               pop,
   output lzv_pkg::rsp_type  rsp_data
);

   // Serializer: remaining value of a multi-byte encode.
   logic                        started_ff, started_in;
   logic [31:0]                 rem_ff, rem_in;

   // Result queue.
   lzv_pkg::rsp_type            out_mem_ff [lzv_pkg::OutDepth];
   logic [lzv_pkg::OutPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lzv_pkg::OutPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lzv_pkg::OutCntW-1:0] count_ff, count_in;

   logic                        out_full;
   logic                        emit, do_rd;
   logic [31:0]                 cur, nxt;
   logic                        beat_last;
   lzv_pkg::rsp_type            beat;

   assign out_full = (count_ff == lzv_pkg::OutCntW'(lzv_pkg::OutDepth));
   assign empty    = (count_ff == '0);
   assign rsp_data = out_mem_ff[rd_ptr_ff];
   assign do_rd    = pop & ~empty;

   assign cur       = started_ff ? rem_ff : job_data.value;
   assign nxt       = cur >> lzv_pkg::GroupBits;
   assign beat_last = job_data.is_decode | (nxt == '0);
   assign emit      = job_valid & ~out_full;
   assign job_pop   = emit & beat_last;

   always_comb begin
      if (job_data.is_decode) begin
         beat.out_byte  = '0;
         beat.out_value = cur;
      end else begin
         beat.out_byte  = {~beat_last, cur[6:0]};
         beat.out_value = '0;
      end
      beat.last = beat_last;
   end

   always_comb begin
      started_in = started_ff;
      rem_in     = rem_ff;
      if (emit) begin
         started_in = ~beat_last;
         rem_in     = nxt;
      end
      wr_ptr_in = emit  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (emit && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !emit) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (emit) begin
         out_mem_ff[wr_ptr_ff] <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         started_ff <= started_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/leb128_zigzag_varint_codec.sv
// 32-bit LEB128 varint codec with optional zigzag mapping. csr_wdata selects
// the mode (0 encode, 1 decode); any write also drops a partly gathered value.
// Write it only while the block is idle. Encode: each input beat carries a
// 32-bit value (zigzag-mapped first when signed_mode is set) and yields one to
// five byte beats, low seven-bit group first, bit 7 set on all but the final
// byte, which carries last. Decode: each input beat is one byte; a byte with
// bit 7 clear, or the fifth byte of a value, yields one value beat (last = 1,
// zigzag-undone when signed_mode is set on that closing byte). Bits above 32
// are dropped. Rate: decode takes one byte per cycle while the job queue has
// space; encode bytes come from the single-byte serializer in the back end,
// which takes a new value only after the last byte of the current one. The
// front end classifies and maps each beat in its accept cycle and hands the
// work over a two-entry job queue; results come out of a two-entry result
// queue, and neither side waits on the other while space remains.
`default_nettype none

module leb128_zigzag_varint_codec (
   input  wire               clock,
   input  wire               reset,
   // configuration
   input  wire               csr_we,
   input  wire               csr_wdata,
   // input beats
   input  wire               push,
   input  lzv_pkg::req_type  req_data,
   output logic              full,
   // result beats
   output logic              empty,
   input  wire               pop,
   output lzv_pkg::rsp_type  rsp_data
);

   logic              jobq_full;
   logic              job_push;
   lzv_pkg::job_type  job_wr;
   logic              job_valid;
   logic              job_pop;
   lzv_pkg::job_type  job_rd;

   // Front end: mode register, decode accumulator, zigzag mapping.
   lzv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .jobq_full (jobq_full),
      .job_push  (job_push),
      .job_data  (job_wr)
   );

   // Decouples classification from byte serialization.
   lzv_jobq u_jobq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wr),
      .q_full  (jobq_full),
      .rd_en   (job_pop),
      .q_valid (job_valid),
      .rd_data (job_rd)
   );

   // Back end: one result beat per cycle, given a job and result queue space.
   lzv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_rd),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/lzv_checker.sv
`default_nettype none

module lzv_checker (
   input wire               clock,
   input wire               reset,
   input wire               full,
   input wire               empty,
   input wire               pop,
   input lzv_pkg::rsp_type  rsp_data
);

   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // A waiting beat holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result beat changed before pop");

   // Continuation bit and last always disagree: encoded mid bytes have bit 7
   // set, final bytes and decoded values have it clear.
   a_cont_last: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.out_byte[7] == !rsp_data.last))
      else $error("continuation bit and last mismatch");

   // A beat carries either a byte or a value, never both.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.out_byte != 8'h00)) |-> (rsp_data.out_value == 32'h0))
      else $error("byte and value both nonzero");

endmodule

bind leb128_zigzag_varint_codec lzv_checker u_lzv_checker (
   .clock     (clock),
   .reset     (reset),
   .full      (full),
   .empty     (empty),
   .pop       (pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
